/* sv/ols_pkg.sv */
// ============================================================================
// Ordered list store package
// Shared constants, codes and types for the ordered list store.
// ============================================================================
`default_nettype none

package ols_pkg;

    // Store geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths.
    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;
    localparam int RES_W     = STATUS_W + 1 + CNT_OUT_W + 1;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((OP_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes.
    localparam t_op OP_ADD_FRONT  = 3'd0;
    localparam t_op OP_ADD_BACK   = 3'd1;
    localparam t_op OP_REM_FRONT  = 3'd2;
    localparam t_op OP_REM_BACK   = 3'd3;
    localparam t_op OP_SEARCH     = 3'd4;
    localparam t_op OP_REM_VALUE  = 3'd5;

    // Status codes.
    localparam t_status STATUS_DONE = 2'd0;
    localparam t_status STATUS_MISS = 2'd1;
    localparam t_status STATUS_FULL = 2'd2;

    // Result layout: status in the lowest bits, is_empty in the highest.
    typedef struct packed {
        logic                 is_empty;
        logic [CNT_OUT_W-1:0] count;
        logic                 found;
        t_status              status;
    } t_result;

endpackage

`default_nettype wire

/* sv/ordered_list_store_core.sv */
// ============================================================================
// Ordered list store core
// Bounded double-ended list of signed 32-bit values with search and
// remove-by-value, built as a small sequencer around one slot-address adder.
// ============================================================================
// Add, remove front/back and unused ops go from the execute state straight to
// the result; search reads and compares each entry visited, and remove-by-value
// then reads and writes each entry moved up to close the gap.
// One request at a time: a new request is taken only once the result has been
// accepted, and each scan or shift step waits on a registered entry read.
// Reset (i_rst_n low, synchronous) empties the list.
`default_nettype none

module ordered_list_store_core
    import ols_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel.
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // Fields from bit 0 up: op[2:0], value[34:3], zero padding.
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // Result channel.
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // Fields from bit 0 up: status[1:0], found[2], count[9:3], is_empty[10],
    // zero padding.
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    // Control state.
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_idx, n_idx;

    // Request and result payload.
    t_op              r_op, n_op;
    logic [VAL_W-1:0] r_value, n_value;
    t_status          r_status, n_status;
    logic             r_found, n_found;

    // Entry memory: one read port with registered data, one write port.
    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;
    logic             w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [VAL_W-1:0] w_wdata;

    // Shared slot unit: maps a position from the front to a buffer index.
    logic [CNT_W-1:0]  w_pos;
    logic [ADDR_W:0]   w_sum;
    logic [ADDR_W-1:0] w_slot;
    logic [ADDR_W-1:0] w_head_dec;

    logic [CNT_W:0]    w_idx_p1;
    logic [CNT_W:0]    w_idx_p2;
    logic [CNT_W:0]    w_count_x;
    logic              w_empty;
    logic              w_full;
    logic              w_accept;

    logic [CNT_W+CNT_OUT_W-1:0] w_count_ext;
    t_result                    w_res;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_idx_p1   = (CNT_W+1)'(r_idx) + (CNT_W+1)'(1);
    assign w_idx_p2   = (CNT_W+1)'(r_idx) + (CNT_W+1)'(2);
    assign w_count_x  = (CNT_W+1)'(r_count);
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count >= CNT_W'(DEPTH));
    assign w_head_dec = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;

    // The slot unit gives the write slot of an add at the back, the new head after
    // a front removal and each scan and shift slot; an add at the front uses w_head_dec.
    always_comb begin
        unique case (r_state)
            S_EXEC:     w_pos = (r_op == OP_ADD_BACK) ? r_count : CNT_W'(1);
            S_SHIFT_RD: w_pos = w_idx_p1[CNT_W-1:0];
            default:    w_pos = r_idx;
        endcase
    end

    assign w_sum  = (ADDR_W+1)'(r_head) + (ADDR_W+1)'(w_pos);
    assign w_slot = (w_sum >= (ADDR_W+1)'(DEPTH)) ?
                    ADDR_W'(w_sum - (ADDR_W+1)'(DEPTH)) : ADDR_W'(w_sum);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_idx    = r_idx;
        n_op     = r_op;
        n_value  = r_value;
        n_status = r_status;
        n_found  = r_found;
        w_we     = 1'b0;
        w_waddr  = w_slot;
        w_wdata  = r_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_s_axis_tdata[OP_W-1:0];
                    n_value = i_s_axis_tdata[OP_W+VAL_W-1:OP_W];
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = STATUS_DONE;
                n_found  = 1'b0;
                n_state  = S_OUT;
                unique case (r_op) inside
                    OP_ADD_FRONT, OP_ADD_BACK: begin
                        if (w_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_op == OP_ADD_FRONT) begin
                                w_waddr = w_head_dec;
                                n_head  = w_head_dec;
                            end
                        end
                    end
                    OP_REM_FRONT: begin
                        if (w_empty) begin
                            n_status = STATUS_MISS;
                        end else begin
                            n_head  = w_slot;
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_REM_BACK: begin
                        if (w_empty) begin
                            n_status = STATUS_MISS;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_SEARCH, OP_REM_VALUE: begin
                        if (w_empty) begin
                            n_status = STATUS_MISS;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end

            S_SCAN_CMP: begin
                if (r_rd_data == r_value) begin
                    n_status = STATUS_DONE;
                    n_found  = 1'b1;
                    if (r_op == OP_SEARCH) begin
                        n_state = S_OUT;
                    end else if (w_idx_p1 < w_count_x) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_count = r_count - 1'b1;
                        n_state = S_OUT;
                    end
                end else if (w_idx_p1 == w_count_x) begin
                    n_status = STATUS_MISS;
                    n_found  = 1'b0;
                    n_state  = S_OUT;
                end else begin
                    n_idx   = w_idx_p1[CNT_W-1:0];
                    n_state = S_SCAN_RD;
                end
            end

            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                // Move the next entry one place toward the front.
                w_we    = 1'b1;
                w_wdata = r_rd_data;
                n_idx   = w_idx_p1[CNT_W-1:0];
                if (w_idx_p2 < w_count_x) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_slot];
    end

    // Result: count and is_empty follow the stored count, which holds still
    // while the result waits.
    assign w_count_ext    = (CNT_W+CNT_OUT_W)'(r_count);
    assign w_res.status   = r_status;
    assign w_res.found    = r_found;
    assign w_res.count    = w_count_ext[CNT_OUT_W-1:0];
    assign w_res.is_empty = w_empty;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = M_TDATA_W'(w_res);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    // A request is never taken while a result is still offered.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("request accepted while result pending");

    // Each request moves the count by at most one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |->
            (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1))
        else $error("element count jumped");

    // A found flag only comes with a done status.
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_found) |-> (r_status == STATUS_DONE))
        else $error("found flag with failing status");

    // The scan index stays inside the live elements.
    a_idx_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP || r_state == S_SHIFT_RD) |-> (r_idx < r_count))
        else $error("scan index outside live elements");

endmodule

`default_nettype wire
